// File: rtl/core/chisq_pkg.sv
// ----------------------------------------------------------------------------
// chisq_pkg
// Shared constants and the result record for the chi-square distance core.
// ----------------------------------------------------------------------------
package chisq_pkg;

    // running sum width and its saturation value
    localparam int SUM_BITS  = 33;
    localparam int DIST_BITS = 32;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 saturated;
    } result_t;

endpackage

// File: rtl/core/chi_square_histogram_distance_core.sv
// ----------------------------------------------------------------------------
// chi_square_histogram_distance_core
// Chi-square distance between two histograms, one bin pair per beat.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction | beat content
//  --------+--------------------------------------+-----------+----------------------
//  in      | in_valid, in_ready, bin_a/b, last_bin| sink      | one matching bin pair
//  out     | out_valid, out_ready, distance, sat. | source    | distance per histogram
//
//  Steps: each bin pair runs from its beat to the next beat through square,
//  one quotient bit a cycle in the bit-serial divider, the divider's done
//  flag, accumulate and idle. An empty pair skips the divider. One beat is
//  in flight at a time.
//  Reset: rst_n clears the control state, the running sum and the flag.
//  Stalls: a result waiting on out_ready does not block new input; only the
//  next last-bin pair waits in its accumulate step until the output is free.
// ----------------------------------------------------------------------------
module chi_square_histogram_distance_core
    import chisq_pkg::*;
#(
    parameter int BIN_BITS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BIN_BITS-1:0]  bin_a,
    input  logic [BIN_BITS-1:0]  bin_b,
    input  logic                 last_bin,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIST_BITS-1:0] distance,
    output logic                 saturated
);

    // dividend (d^2 << FRAC_BITS), divisor (a + b), term width
    localparam int DW = 2 * BIN_BITS + FRAC_BITS;
    localparam int SW = BIN_BITS + 1;
    localparam int TW = BIN_BITS + FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [BIN_BITS-1:0] a_reg, b_reg;
    logic                last_reg;
    logic                zero_reg, zero_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;

    logic                in_fire;
    logic [BIN_BITS-1:0] diff;
    logic [2*BIN_BITS-1:0] sq;
    logic [SW-1:0]       bsum;
    logic [DW-1:0]       dividend;
    logic                div_start;
    logic                div_done;
    logic [DW-1:0]       quot;
    logic [TW-1:0]       term;
    logic                out_free;
    logic                acc_en;
    result_t             acc_res;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // |a - b|, its square and the bin sum; the divider loads the shifted square directly
    assign diff     = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign sq       = (2*BIN_BITS)'(diff) * (2*BIN_BITS)'(diff);
    assign bsum     = SW'(a_reg) + SW'(b_reg);
    assign dividend = DW'(sq) << FRAC_BITS;

    // empty bin pair skips the divide and adds zero
    assign div_start = (state_reg == S_SQ) && (bsum != '0);

    chisq_div #(
        .DVD_BITS (DW),
        .SOR_BITS (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (bsum),
        .done     (div_done),
        .quotient (quot)
    );

    // quotient never exceeds max(a,b) << FRAC_BITS, so TW bits hold it
    assign term = zero_reg ? '0 : quot[TW-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign acc_en   = (state_reg == S_ACC) && (!last_reg || out_free);

    chisq_acc #(
        .TERM_BITS (TW)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .add_en (acc_en),
        .last   (last_reg),
        .term   (term),
        .result (acc_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                zero_next  = (bsum == '0);
                state_next = (bsum == '0) ? S_ACC : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_en)
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        res_next       = acc_res;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg    <= bin_a;
            b_reg    <= bin_b;
            last_reg <= last_bin;
        end
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = res_reg.distance;
    assign saturated = res_reg.saturated;

endmodule

// File: rtl/core/chisq_div.sv
// ----------------------------------------------------------------------------
// chisq_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend MSB first.
// ----------------------------------------------------------------------------
module chisq_div #(
    parameter int DVD_BITS = 40,
    parameter int SOR_BITS = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [SOR_BITS-1:0] divisor,
    output logic                done,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int RW = SOR_BITS + 1;
    localparam int CW = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;

    logic [DVD_BITS-1:0] dvd_reg, dvd_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [SOR_BITS-1:0] sor_reg, sor_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [RW-1:0]       trial;
    logic                ge;

    // remainder stays below the divisor, so the shifted trial fits RW bits
    assign trial = {rem_reg[RW-2:0], dvd_reg[DVD_BITS-1]};
    assign ge    = (trial >= {1'b0, sor_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        sor_next  = sor_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            sor_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - {1'b0, sor_reg}) : trial;
            dvd_next = {dvd_reg[DVD_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DVD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        sor_reg <= sor_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: rtl/core/chisq_acc.sv
// ----------------------------------------------------------------------------
// chisq_acc
// Saturating running sum of chi-square terms, cleared after the last bin.
// ----------------------------------------------------------------------------
module chisq_acc
    import chisq_pkg::*;
#(
    parameter int TERM_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 add_en,
    input  logic                 last,
    input  logic [TERM_BITS-1:0] term,
    output result_t              result
);

    localparam int AW = ((TERM_BITS > SUM_BITS) ? TERM_BITS : SUM_BITS) + 1;

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                clip_reg, clip_next;
    logic [AW-1:0]       total;
    logic                over;
    logic [SUM_BITS-1:0] sum_add;
    logic                clip_add;

    assign total    = AW'(sum_reg) + AW'(term);
    assign over     = (total >= AW'(SUM_MAX));
    assign sum_add  = over ? SUM_MAX : total[SUM_BITS-1:0];
    assign clip_add = clip_reg | over;

    // result reflects the sum including the current term
    assign result.distance  = sum_add[SUM_BITS-1:1];
    assign result.saturated = clip_add;

    always_comb
    begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (add_en)
        begin
            sum_next  = last ? '0 : sum_add;
            clip_next = last ? 1'b0 : clip_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            clip_reg <= clip_next;
        end
    end

endmodule

// File: rtl/core/chisq_checker.sv
// ----------------------------------------------------------------------------
// chisq_checker
// Port-level checks for the chi-square distance core, bound to the top level.
// ----------------------------------------------------------------------------
module chisq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] distance,
    input logic        saturated
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(saturated))
        else $error("result changed while stalled");

    // an accepted pair keeps the input closed through the square step and the step after it
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input reopened too early");

    // a clipped sum sits at its maximum, so the distance is all ones
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> distance == 32'hFFFF_FFFF)
        else $error("saturated result below maximum");

endmodule

bind chi_square_histogram_distance_core chisq_checker u_chisq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance),
    .saturated (saturated)
);

// File: bench/chisq_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chisq_distance_checker
// Watches both channels of the chi-square distance core. Each bin pair
// accepted on the input channel is folded into its own running sum. A
// last-bin pair queues the expected distance and saturation flag. Each result
// accepted on the output channel is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module chisq_distance_checker
    import chisq_pkg::*;
#(
    parameter int BIN_BITS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [BIN_BITS-1:0]  bin_a,
    input  logic [BIN_BITS-1:0]  bin_b,
    input  logic                 last_bin,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [DIST_BITS-1:0] distance,
    input  logic                 saturated,
    output int                   fail_count,
    output int                   pending
);

    logic [SUM_BITS-1:0] hist_sum     = '0;
    logic                hist_clipped = 1'b0;
    result_t             distance_q[$];
    int                  errors       = 0;
    int                  queued       = 0;

    assign fail_count = errors;
    assign pending    = queued;

    // floor((a-b)^2 * 2^FRAC_BITS / (a+b)), split as quotient and remainder
    // so the fraction bits stay exact; an empty pair contributes nothing
    function automatic logic [63:0] pair_term(input logic [BIN_BITS-1:0] a,
                                              input logic [BIN_BITS-1:0] b);
        logic [63:0] diff;
        logic [63:0] total;
        logic [63:0] sq;
        logic [63:0] quo;
        logic [63:0] rem;
        total = 64'(a) + 64'(b);
        diff  = (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
        if (total == 64'd0)
            return 64'd0;
        sq  = diff * diff;
        quo = sq / total;
        rem = sq % total;
        return (quo << FRAC_BITS) + ((rem << FRAC_BITS) / total);
    endfunction

    always @(posedge clk) begin : track
        logic [63:0] next_sum;
        logic [SUM_BITS-1:0] sum_now;
        logic clip_now;
        result_t want;
        if (rst_n) begin
            // result side first: a beat out can never stem from this edge's input
            if (out_valid && out_ready) begin
                if (distance_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t distance_check: result with nothing expected, got %0d/%0b",
                             $time, distance, saturated);
                end else begin
                    want = distance_q.pop_front();
                    if (distance !== want.distance) begin
                        errors = errors + 1;
                        $display("%0t distance_check: distance expected %0d, got %0d",
                                 $time, want.distance, distance);
                    end
                    if (saturated !== want.saturated) begin
                        errors = errors + 1;
                        $display("%0t distance_check: saturated expected %0b, got %0b",
                                 $time, want.saturated, saturated);
                    end
                end
            end

            if (in_valid && in_ready) begin
                next_sum = 64'(hist_sum) + pair_term(bin_a, bin_b);
                if (next_sum >= 64'(SUM_MAX)) begin
                    sum_now  = SUM_MAX;
                    clip_now = 1'b1;
                end else begin
                    sum_now  = next_sum[SUM_BITS-1:0];
                    clip_now = hist_clipped;
                end
                if (last_bin) begin
                    want.distance  = sum_now[SUM_BITS-1:1];
                    want.saturated = clip_now;
                    distance_q.insert(distance_q.size(), want);
                    hist_sum     <= '0;
                    hist_clipped <= 1'b0;
                end else begin
                    hist_sum     <= sum_now;
                    hist_clipped <= clip_now;
                end
            end
            queued <= distance_q.size();
        end
    end

endmodule

// File: bench/tb_chi_square_histogram_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chi_square_histogram_distance_core
// Drives bin pairs into the chi-square distance core and hands checking to
// chisq_distance_checker. A short directed run covers the bin extremes, empty
// pairs and multi-pair histograms. Random histograms follow, plus one long
// histogram of heavy bins that drives the running sum into saturation.
// ----------------------------------------------------------------------------
module tb_chi_square_histogram_distance_core;
    import chisq_pkg::*;

    localparam int BIN_BITS   = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ITEMS      = 1050;   // no new histogram once this many pairs went in
    localparam int HEAVY_LEN  = 560;    // pairs in the histogram that saturates
    localparam int HEAVY_AT   = 400;    // start it once this many pairs went in
    // give the tail time to flush anything stray out of the core
    localparam int TAIL       = 100;
    // idle cycles with no beat on either channel before giving up; the worst
    // honest wait is one pair time plus the longest sender gap plus a long
    // receiver stall
    localparam int IDLE_LIMIT = 4000;

    localparam logic [BIN_BITS-1:0] BIN_MAX = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BIN_BITS-1:0]  bin_a     = '0;
    logic [BIN_BITS-1:0]  bin_b     = '0;
    logic                 last_bin  = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DIST_BITS-1:0] distance;
    logic                 saturated;

    int fail_count;
    int pending;
    int sent_count = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // receiver stall pattern state
    int       stall_mode  = 0;
    int       stall_left  = 0;
    logic [7:0] stall_mask = 8'hFF;
    logic [2:0] stall_phase = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chi_square_histogram_distance_core #(
        .BIN_BITS  (BIN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .bin_a     (bin_a),
        .bin_b     (bin_b),
        .last_bin  (last_bin),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .saturated (saturated)
    );

    chisq_distance_checker #(
        .BIN_BITS  (BIN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) distance_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .bin_a      (bin_a),
        .bin_b      (bin_b),
        .last_bin   (last_bin),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance   (distance),
        .saturated  (saturated),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // One bin pair per beat. Starts at a falling edge, returns at the rising
    // edge that took the beat, leaving in_valid high: the next call either
    // puts a new pair on the bus or drops valid for a gap, never both in one
    // step. Bursts of random length are split by random gaps.
    task automatic send_pair(input logic [BIN_BITS-1:0] a_val,
                             input logic [BIN_BITS-1:0] b_val,
                             input logic is_last);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                              : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            // an occasional long burst keeps stretches with no sender idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        bin_a    <= a_val;
        bin_b    <= b_val;
        last_bin <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    // drop valid and hold off until every queued distance has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: every so often pick a new stall style - always ready,
    // coin flip, mostly stalled, or a rotating 8-bit mask.
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 200);
            stall_mask <= 8'($urandom) | 8'h01;
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= stall_phase + 3'd1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 5) == 0);
            default: out_ready <= stall_mask[stall_phase];
        endcase
    end

    // Watchdog: any beat on either side counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_chi_square_histogram_distance_core: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int hist_len;
        int shape;
        logic [BIN_BITS-1:0] a_val;
        logic [BIN_BITS-1:0] b_val;
        bit heavy_done;

        heavy_done = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---------------------------------------------------
        // empty pair alone: nothing added, distance zero
        send_pair('0, '0, 1'b1);
        // one side full, other empty, both ways: largest single term
        send_pair(BIN_MAX, '0, 1'b1);
        send_pair('0, BIN_MAX, 1'b1);
        // equal full bins: zero term
        send_pair(BIN_MAX, BIN_MAX, 1'b1);
        // multi-pair histogram with an empty pair in the middle
        send_pair(16'd1, 16'd0, 1'b0);
        send_pair(16'd0, 16'd1, 1'b0);
        send_pair(16'd3, 16'd5, 1'b0);
        send_pair('0, '0, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b1);
        // alternating bit patterns and near-equal large bins
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'd1, BIN_MAX, 1'b0);
        send_pair(BIN_MAX - 16'd1, BIN_MAX, 1'b1);
        // histogram made only of empty pairs
        send_pair('0, '0, 1'b0);
        send_pair('0, '0, 1'b1);
        // bins either side of half scale, and a remainder-heavy pair
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h00FF, 16'hFF00, 1'b1);
        drain();

        // --- random histograms --------------------------------------------
        while (sent_count < ITEMS) begin
            if (!heavy_done && sent_count >= HEAVY_AT) begin
                // heavy bins: each term is 16.4M to 16.8M, so the 33-bit sum
                // clips between pairs 513 and 524 and must stay clipped to the end
                for (int i = 0; i < HEAVY_LEN; i++)
                    send_pair(BIN_BITS'($urandom_range(65000, 65535)),
                              BIN_BITS'($urandom_range(0, 300)),
                              i == HEAVY_LEN - 1);
                heavy_done = 1'b1;
            end else begin
                hist_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
                for (int i = 0; i < hist_len; i++) begin
                    shape = $urandom_range(0, 5);
                    a_val = BIN_BITS'($urandom);
                    b_val = BIN_BITS'($urandom);
                    case (shape)
                        1: begin            // sparse bins, small counts
                            a_val = BIN_BITS'($urandom_range(0, 15));
                            b_val = BIN_BITS'($urandom_range(0, 15));
                        end
                        2: b_val = a_val;   // identical bins
                        3: begin            // one histogram empty here
                            if ($urandom_range(0, 1) == 0)
                                a_val = '0;
                            else
                                b_val = '0;
                        end
                        4: b_val = a_val ^ (BIN_BITS'(1) << $urandom_range(0, BIN_BITS - 1));
                        default: ;
                    endcase
                    send_pair(a_val, b_val, i == hist_len - 1);
                end
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (TAIL) @(negedge clk);
        if (fail_count == 0)
            $display("tb_chi_square_histogram_distance_core: done, clean");
        else
            $display("tb_chi_square_histogram_distance_core: done, errors");
        $finish;
    end

endmodule
